@@ src/pps_pkg.sv @@
// Shared constants and types of the preemptive priority scheduler.
package pps_pkg;

    // Number of task slots in the chain of cells.
    localparam int SLOTS     = 16;
    // Width of the scheduler time base.
    localparam int TIME_BITS = 16;
    // Field widths fixed by the interface.
    localparam int BURST_W   = 16;
    localparam int URG_W     = 8;
    localparam int OUT_W     = 16;
    localparam int RUN_W     = 4;

    // Derived widths.
    localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W     = $clog2(SLOTS + 1);
    localparam int CMP_W     = (TIME_BITS > BURST_W) ? TIME_BITS : BURST_W;

    // Command codes of an input transfer.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [BURST_W-1:0]   t_burst;
    typedef logic [URG_W-1:0]     t_urg;
    typedef logic [SLOT_W-1:0]    t_slot;
    typedef logic [CNT_W-1:0]     t_cnt;

    // Best candidate so far, handed from cell to cell along the chain.
    typedef struct packed {
        logic   found;
        t_urg   urgency;
        t_slot  slot;
        t_time  arrival;
        t_burst burst;
        logic   last;
    } t_token;

    // Control broadcast from the controller to every cell.
    typedef struct packed {
        logic   load_en;
        logic   dec_en;
        t_slot  slot;
        t_time  arrival;
        t_burst burst;
        t_urg   urgency;
    } t_cell_ctl;

endpackage

@@ src/pps_cell.sv @@
// One task slot of the scheduler chain: holds the task and passes on the best candidate.
module pps_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pps_pkg::t_slot     i_index,
    input  pps_pkg::t_time     i_now,
    input  pps_pkg::t_cell_ctl i_ctl,
    input  pps_pkg::t_token    i_tok,
    output pps_pkg::t_token    o_tok
);

    logic             r_loaded;
    pps_pkg::t_time   r_arrival;
    pps_pkg::t_burst  r_burst;
    pps_pkg::t_burst  r_remaining;
    pps_pkg::t_urg    r_urgency;
    pps_pkg::t_token  r_tok;
    pps_pkg::t_token  n_tok;
    logic             eligible;
    logic             take;

    // Valid flag of the slot; set by a load, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loaded <= 1'b0;
        end else if (i_ctl.load_en && i_ctl.slot == i_index) begin
            r_loaded <= 1'b1;
        end
    end

    // Task fields: written on load, remaining work counted down when this slot runs.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_en && i_ctl.slot == i_index) begin
            r_arrival   <= i_ctl.arrival;
            r_burst     <= i_ctl.burst;
            r_remaining <= i_ctl.burst;
            r_urgency   <= i_ctl.urgency;
        end else if (i_ctl.dec_en && i_ctl.slot == i_index) begin
            r_remaining <= r_remaining - pps_pkg::BURST_W'(1);
        end
    end

    // This slot replaces the incoming candidate only with a strictly higher urgency,
    // so on a tie the lower slot keeps its place.
    always_comb begin
        eligible = r_loaded && (r_arrival <= i_now) && (r_remaining != '0);
        take     = eligible && (!i_tok.found || (r_urgency > i_tok.urgency));
        n_tok    = i_tok;
        if (take) begin
            n_tok.found   = 1'b1;
            n_tok.urgency = r_urgency;
            n_tok.slot    = i_index;
            n_tok.arrival = r_arrival;
            n_tok.burst   = r_burst;
            n_tok.last    = (r_remaining == pps_pkg::BURST_W'(1));
        end
    end

    // Candidate register towards the next cell.
    always_ff @(posedge i_clk) begin
        r_tok <= n_tok;
    end

    assign o_tok = r_tok;

endmodule

@@ src/pps_ctrl.sv @@
// Sequencer of the scheduler: loads, scan timing, bookkeeping and result registers.
module pps_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_command,
    input  pps_pkg::t_time     i_arrival,
    input  pps_pkg::t_burst    i_burst,
    input  pps_pkg::t_urg      i_urgency,
    input  pps_pkg::t_token    i_best,
    output pps_pkg::t_time     o_now,
    output pps_pkg::t_cell_ctl o_ctl,
    output logic               o_valid,
    output logic [15:0]        o_tick_time,
    output logic [3:0]         o_run_slot,
    output logic               o_idle,
    output logic               o_segment_start,
    output logic               o_finished,
    output logic [15:0]        o_wait_time,
    output logic [15:0]        o_turnaround_time,
    output logic               o_all_done
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_UPDATE = 3'b100
    } t_state;

    t_state                r_state;
    t_state                n_state;
    pps_pkg::t_slot        r_scan_cnt;
    pps_pkg::t_cnt         r_loaded_cnt;
    pps_pkg::t_cnt         r_done_cnt;
    pps_pkg::t_cnt         n_done_cnt;
    pps_pkg::t_time        r_now;
    pps_pkg::t_time        n_now;
    pps_pkg::t_slot        r_prev_slot;
    logic                  r_prev_valid;
    logic                  r_valid;
    logic [15:0]           r_tick_time;
    logic [3:0]            r_run_slot;
    logic                  r_idle;
    logic                  r_seg;
    logic                  r_fin;
    logic [15:0]           r_wait;
    logic [15:0]           r_turn;
    logic                  r_all_done;
    logic                  accept;
    logic                  do_load;
    logic                  fin;
    logic                  seg;
    pps_pkg::t_time        turn;
    logic [pps_pkg::CMP_W-1:0] turn_x;
    logic [pps_pkg::CMP_W-1:0] burst_x;
    logic [pps_pkg::CMP_W-1:0] wait_x;

    assign busy    = (r_state != ST_IDLE);
    assign accept  = start && !busy;
    assign do_load = accept && (i_command == pps_pkg::CMD_LOAD)
                     && (r_loaded_cnt < pps_pkg::CNT_W'(pps_pkg::SLOTS));

    // State sequencing: a tick scans the whole chain, then updates and returns to idle.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_command == pps_pkg::CMD_TICK) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_scan_cnt == pps_pkg::SLOT_W'(pps_pkg::SLOTS - 1)) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Tick arithmetic on the winning candidate at the end of the chain.
    always_comb begin
        n_now   = (r_now != '1) ? (r_now + pps_pkg::TIME_BITS'(1)) : r_now;
        fin     = i_best.found && i_best.last;
        seg     = i_best.found && (!r_prev_valid || (r_prev_slot != i_best.slot));
        turn    = n_now - i_best.arrival;
        turn_x  = pps_pkg::CMP_W'(turn);
        burst_x = pps_pkg::CMP_W'(i_best.burst);
        wait_x  = (turn_x >= burst_x) ? (turn_x - burst_x) : '0;
        n_done_cnt = r_done_cnt + pps_pkg::CNT_W'(fin);
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_scan_cnt   <= '0;
            r_loaded_cnt <= '0;
            r_done_cnt   <= '0;
            r_now        <= '0;
            r_prev_slot  <= '0;
            r_prev_valid <= 1'b0;
            r_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_UPDATE);
            if (r_state == ST_SCAN) begin
                r_scan_cnt <= r_scan_cnt + pps_pkg::SLOT_W'(1);
            end else begin
                r_scan_cnt <= '0;
            end
            if (do_load) begin
                r_loaded_cnt <= r_loaded_cnt + pps_pkg::CNT_W'(1);
                if (i_burst == '0) begin
                    r_done_cnt <= r_done_cnt + pps_pkg::CNT_W'(1);
                end
            end
            if (r_state == ST_UPDATE) begin
                r_now      <= n_now;
                r_done_cnt <= n_done_cnt;
                if (i_best.found) begin
                    r_prev_slot  <= i_best.slot;
                    r_prev_valid <= !fin;
                end
            end
        end
    end

    // Result registers, written in the update state and held until the next update.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_UPDATE) begin
            r_tick_time <= 16'(r_now);
            r_run_slot  <= i_best.found ? 4'(i_best.slot) : 4'd0;
            r_idle      <= !i_best.found;
            r_seg       <= seg;
            r_fin       <= fin;
            r_wait      <= fin ? 16'(wait_x) : 16'd0;
            r_turn      <= fin ? 16'(turn) : 16'd0;
            r_all_done  <= (n_done_cnt == r_loaded_cnt);
        end
    end

    // Broadcast to the cells: loads in idle, the count-down in the update cycle.
    always_comb begin
        o_ctl.load_en = do_load;
        o_ctl.dec_en  = (r_state == ST_UPDATE) && i_best.found;
        o_ctl.slot    = (r_state == ST_UPDATE) ? i_best.slot
                                               : r_loaded_cnt[pps_pkg::SLOT_W-1:0];
        o_ctl.arrival = i_arrival;
        o_ctl.burst   = i_burst;
        o_ctl.urgency = i_urgency;
    end

    assign o_now             = r_now;
    assign o_valid           = r_valid;
    assign o_tick_time       = r_tick_time;
    assign o_run_slot        = r_run_slot;
    assign o_idle            = r_idle;
    assign o_segment_start   = r_seg;
    assign o_finished        = r_fin;
    assign o_wait_time       = r_wait;
    assign o_turnaround_time = r_turn;
    assign o_all_done        = r_all_done;

    // A result is only shown in the cycle after an update.
    a_valid_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == ST_UPDATE))
        else $error("result strobe without a preceding update");

    // An idle tick neither completes a task nor starts a segment.
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_idle) |-> (!o_finished && !o_segment_start))
        else $error("idle tick reports activity");

    // No more tasks can be done than were loaded.
    a_done_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done_cnt <= r_loaded_cnt)
        else $error("done count exceeds loaded count");

    // A tick transfer always leads to a full scan before the update.
    a_scan_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_command == pps_pkg::CMD_TICK)
        |=> (r_state == ST_SCAN && r_scan_cnt == '0))
        else $error("tick did not start a scan");

endmodule

@@ src/preemptive_priority_scheduler_core.sv @@
// Top level of the preemptive priority scheduler: controller and chain of slot cells.
//
// Usage: drive i_command, i_arrival, i_burst and i_urgency with start high; the
// transfer happens at the rising edge where start is high and busy is low.
// A load command (0) writes the next free slot in the same cycle and keeps busy
// low, so loads may follow one per cycle; loads beyond the last slot are dropped.
// A tick command (1) raises busy while the chain is scanned and updated: the
// best candidate travels one cell per cycle down the chain of slots, and the
// update state then applies the count-down and the timing arithmetic. The
// result transfer follows as a one-cycle o_valid strobe right after busy
// falls; the next item may be taken in the strobe cycle. Loads produce no
// result.
// The receiver cannot hold results off; o_valid is high for exactly one cycle.
// Reset (i_rst_n low, synchronous) empties the table, clears time and counts
// and forgets the running task; the slot contents themselves are not cleared.
module preemptive_priority_scheduler_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_command,
    input  logic [15:0] i_arrival,
    input  logic [15:0] i_burst,
    input  logic [7:0]  i_urgency,
    output logic        o_valid,
    output logic [15:0] o_tick_time,
    output logic [3:0]  o_run_slot,
    output logic        o_idle,
    output logic        o_segment_start,
    output logic        o_finished,
    output logic [15:0] o_wait_time,
    output logic [15:0] o_turnaround_time,
    output logic        o_all_done
);

    pps_pkg::t_token    tok_chain [pps_pkg::SLOTS+1];
    pps_pkg::t_cell_ctl cell_ctl;
    pps_pkg::t_time     now;

    assign tok_chain[0] = '0;

    // Controller.
    pps_ctrl u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_command         (i_command),
        .i_arrival         (pps_pkg::TIME_BITS'(i_arrival)),
        .i_burst           (pps_pkg::BURST_W'(i_burst)),
        .i_urgency         (pps_pkg::URG_W'(i_urgency)),
        .i_best            (tok_chain[pps_pkg::SLOTS]),
        .o_now             (now),
        .o_ctl             (cell_ctl),
        .o_valid           (o_valid),
        .o_tick_time       (o_tick_time),
        .o_run_slot        (o_run_slot),
        .o_idle            (o_idle),
        .o_segment_start   (o_segment_start),
        .o_finished        (o_finished),
        .o_wait_time       (o_wait_time),
        .o_turnaround_time (o_turnaround_time),
        .o_all_done        (o_all_done)
    );

    // Chain of slot cells, slot 0 at the head.
    for (genvar g = 0; g < pps_pkg::SLOTS; g++) begin : g_cell
        pps_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (pps_pkg::SLOT_W'(g)),
            .i_now   (now),
            .i_ctl   (cell_ctl),
            .i_tok   (tok_chain[g]),
            .o_tok   (tok_chain[g+1])
        );
    end

endmodule
